// ===== design/ep0_req_pkg.sv =====
`default_nettype none

package ep0_req_pkg;

  localparam int NUM_ENDPOINTS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] NUM_CONFIGURATIONS_RESET = 8'd1;

  localparam logic [2:0] DS_INIT       = 3'd0;
  localparam logic [2:0] DS_CREATED    = 3'd1;
  localparam logic [2:0] DS_ATTACHED   = 3'd2;
  localparam logic [2:0] DS_POWERED    = 3'd3;
  localparam logic [2:0] DS_DEFAULT    = 3'd4;
  localparam logic [2:0] DS_ADDRESSED  = 3'd5;
  localparam logic [2:0] DS_CONFIGURED = 3'd6;
  localparam logic [2:0] DS_UNKNOWN    = 3'd7;

  localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] RQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] RQ_SET_DESCRIPTOR    = 8'd7;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] RQ_SYNCH_FRAME       = 8'd12;

  localparam logic [1:0] TYPE_STANDARD = 2'd0;

  localparam logic [4:0] RCP_DEVICE   = 5'd0;
  localparam logic [4:0] RCP_ENDPOINT = 5'd2;
  localparam logic [4:0] RCP_OTHER    = 5'd3;

  localparam logic [7:0] DT_DEVICE        = 8'd1;
  localparam logic [7:0] DT_CONFIGURATION = 8'd2;
  localparam logic [7:0] DT_STRING        = 8'd3;

  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_ADDRESS    = 2'd1;
  localparam logic [1:0] EV_CONFIGURED = 2'd2;
  localparam logic [1:0] EV_INTERFACE  = 2'd3;

  typedef enum logic [2:0] {
    OUT_ACK      = 3'd0,
    OUT_DATA     = 3'd1,
    OUT_STALL    = 3'd2,
    OUT_DESC     = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_STALL,
    OP_DATA_FIXED,
    OP_STATUS_EP,
    OP_DESC,
    OP_GET_CONFIG,
    OP_GET_ALT,
    OP_HALT_SET,
    OP_HALT_CLR,
    OP_SET_ADDR,
    OP_SET_CONFIG,
    OP_SET_IFACE
  } op_t;

  typedef struct packed {
    logic [2:0]  usb_state;
    logic [7:0]  request_type_byte;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
  } req_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [1:0]  data_length;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [1:0]  event_code;
    logic        send_ack;
    logic [7:0]  descriptor_kind;
    logic [7:0]  descriptor_number;
    logic [15:0] descriptor_max_length;
    logic [6:0]  current_address;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  ep;
    logic [1:0]  data_length;
    logic        byte0_bit;
    logic [15:0] value_word;
    logic [15:0] length_word;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/usb_ep0_standard_request_handler.sv =====
// Standard request decoder for the USB control endpoint zero.
// A SETUP request enters through push/full with the current device state and
// leaves as one result on the empty/pop side. The front stage classifies the
// request against the number of configurations and writes a command
// into a two-entry queue. The back stage executes commands in order against
// the address, configuration, alternate setting and endpoint halt state, and
// writes each result into a two-entry output queue.
// A pushed request waits in the command queue; the back stage writes its
// result into the output queue while that queue has room. One request is
// accepted per cycle while full is low; one result per cycle while pop is high.
// When pop is held low, the output queue fills, the back stage stops, the
// command queue fills and full rises; nothing is lost.
// The always-ready configuration channel writes the number of configurations.
// The user must write it only while no request is in flight (not enforced).
// Reset empties both queues, clears the address, configuration, alternate
// setting and all halt bits, and sets the number of configurations to one.
`default_nettype none

module usb_ep0_standard_request_handler
  import ep0_req_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire req_t       req,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  output logic            empty,
  input  wire logic       pop,
  output rsp_t            rsp
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  rsp_t back_rsp;
  logic cmd_empty;
  logic out_full;
  logic back_fire;

  assign cfg_ready = 1'b1;
  assign back_fire = !cmd_empty && !out_full;

  ep0_req_front #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (front_cmd)
  );

  ep0_req_fifo #(
    .T(cmd_t)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .wdata(front_cmd),
    .pop  (back_fire),
    .empty(cmd_empty),
    .rdata(back_cmd)
  );

  ep0_req_back #(
    .NUM_ENDPOINTS(NUM_ENDPOINTS)
  ) u_back (
    .clk (clk),
    .rst (rst),
    .fire(back_fire),
    .cmd (back_cmd),
    .rsp (back_rsp)
  );

  ep0_req_fifo #(
    .T(rsp_t)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (back_fire),
    .full (out_full),
    .wdata(back_rsp),
    .pop  (pop),
    .empty(empty),
    .rdata(rsp)
  );

endmodule

`default_nettype wire

// ===== design/ep0_req_fifo.sv =====
`default_nettype none

module ep0_req_fifo
  import ep0_req_pkg::*;
#(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire T     wdata,
  input  wire logic pop,
  output logic      empty,
  output T          rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  T mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ep0_req_front.sv =====
`default_nettype none

module ep0_req_front
  import ep0_req_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire req_t       req,
  output cmd_t            cmd
);

  logic [7:0] num_configurations;
  logic [4:0] recip;
  logic [6:0] ep;
  logic       ep_ok;
  logic [7:0] kind;
  logic [7:0] num;
  logic       early_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_configurations <= NUM_CONFIGURATIONS_RESET;
    end else if (cfg_valid) begin
      num_configurations <= cfg_data;
    end
  end

  assign recip = req.request_type_byte[4:0];
  assign ep    = req.index_word[6:0];
  assign ep_ok = ({1'b0, ep} < 8'(NUM_ENDPOINTS));
  assign kind  = req.value_word[15:8];
  assign num   = req.value_word[7:0];

  assign early_stall =
      (req.usb_state == DS_INIT || req.usb_state == DS_DEFAULT) &&
      (req.request_code == RQ_GET_STATUS || req.request_code == RQ_CLEAR_FEATURE ||
       req.request_code == RQ_SET_FEATURE || req.request_code == RQ_SET_DESCRIPTOR ||
       req.request_code == RQ_GET_INTERFACE || req.request_code == RQ_SET_INTERFACE ||
       req.request_code == RQ_SYNCH_FRAME);

  always_comb begin
    cmd             = '0;
    cmd.op          = OP_STALL;
    cmd.ep          = ep;
    cmd.value_word  = req.value_word;
    cmd.length_word = req.length_word;
    if (req.request_type_byte[6:5] != TYPE_STANDARD) begin
      cmd.op = OP_IGNORE;
    end else if (req.usb_state inside {DS_CREATED, DS_ATTACHED, DS_POWERED,
                                       DS_UNKNOWN}) begin
      cmd.op = OP_STALL;
    end else if (early_stall) begin
      cmd.op = OP_STALL;
    end else if (req.request_type_byte[7]) begin
      case (req.request_code)
        RQ_GET_STATUS: begin
          if (recip == RCP_DEVICE) begin
            cmd.op          = OP_DATA_FIXED;
            cmd.data_length = 2'd2;
            cmd.byte0_bit   = 1'b1;
          end else if (recip == RCP_ENDPOINT) begin
            cmd.op = ep_ok ? OP_STATUS_EP : OP_STALL;
          end else if (recip == RCP_OTHER) begin
            cmd.op          = OP_DATA_FIXED;
            cmd.data_length = 2'd0;
          end else begin
            cmd.op          = OP_DATA_FIXED;
            cmd.data_length = 2'd2;
          end
        end
        RQ_GET_DESCRIPTOR: begin
          if (kind == DT_DEVICE || kind == DT_STRING) begin
            cmd.op = OP_DESC;
          end else if (kind == DT_CONFIGURATION && num < num_configurations) begin
            cmd.op = OP_DESC;
          end else begin
            cmd.op = OP_STALL;
          end
        end
        RQ_GET_CONFIGURATION: cmd.op = OP_GET_CONFIG;
        RQ_GET_INTERFACE:     cmd.op = OP_GET_ALT;
        default:              cmd.op = OP_STALL;
      endcase
    end else begin
      case (req.request_code)
        RQ_CLEAR_FEATURE, RQ_SET_FEATURE: begin
          if (recip == RCP_ENDPOINT && req.value_word == 16'd0 && ep_ok) begin
            cmd.op = (req.request_code == RQ_SET_FEATURE) ? OP_HALT_SET : OP_HALT_CLR;
          end else begin
            cmd.op = OP_STALL;
          end
        end
        RQ_SET_ADDRESS: begin
          cmd.op = (req.usb_state == DS_DEFAULT) ? OP_SET_ADDR : OP_STALL;
        end
        RQ_SET_CONFIGURATION: cmd.op = OP_SET_CONFIG;
        RQ_SET_INTERFACE:     cmd.op = OP_SET_IFACE;
        default:              cmd.op = OP_STALL;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ep0_req_back.sv =====
`default_nettype none

module ep0_req_back
  import ep0_req_pkg::*;
#(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire cmd_t cmd,
  output rsp_t      rsp
);

  localparam int EP_W = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  logic [6:0]               device_address;
  logic [7:0]               active_configuration;
  logic [7:0]               active_alternate;
  logic [NUM_ENDPOINTS-1:0] endpoint_halted;
  logic [EP_W-1:0]          ep_idx;
  logic [6:0]               cfg_sel;

  assign ep_idx  = cmd.ep[EP_W-1:0];
  assign cfg_sel = cmd.value_word[6:0];

  always_comb begin
    rsp                 = '0;
    rsp.outcome         = OUT_ACK;
    rsp.current_address = device_address;
    case (cmd.op)
      OP_IGNORE: rsp.outcome = OUT_IGNORED;
      OP_STALL:  rsp.outcome = OUT_STALL;
      OP_DATA_FIXED: begin
        rsp.outcome     = OUT_DATA;
        rsp.data_length = cmd.data_length;
        rsp.data_byte0  = {7'd0, cmd.byte0_bit};
      end
      OP_STATUS_EP: begin
        rsp.outcome     = OUT_DATA;
        rsp.data_length = 2'd2;
        rsp.data_byte0  = {7'd0, endpoint_halted[ep_idx]};
      end
      OP_DESC: begin
        rsp.outcome               = OUT_DESC;
        rsp.descriptor_kind       = cmd.value_word[15:8];
        rsp.descriptor_number     = cmd.value_word[7:0];
        rsp.descriptor_max_length = cmd.length_word;
      end
      OP_GET_CONFIG: begin
        rsp.outcome     = OUT_DATA;
        rsp.data_length = 2'd1;
        rsp.data_byte0  = active_configuration;
      end
      OP_GET_ALT: begin
        rsp.outcome     = OUT_DATA;
        rsp.data_length = 2'd1;
        rsp.data_byte0  = active_alternate;
      end
      OP_HALT_SET, OP_HALT_CLR: rsp.outcome = OUT_ACK;
      OP_SET_ADDR: begin
        rsp.event_code      = EV_ADDRESS;
        rsp.current_address = cmd.value_word[6:0];
      end
      OP_SET_CONFIG: begin
        rsp.event_code = EV_CONFIGURED;
        rsp.send_ack   = 1'b1;
      end
      OP_SET_IFACE: begin
        rsp.event_code = EV_INTERFACE;
        rsp.send_ack   = 1'b1;
      end
      default: rsp.outcome = OUT_STALL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address       <= '0;
      active_configuration <= '0;
      active_alternate     <= '0;
      endpoint_halted      <= '0;
    end else if (fire) begin
      case (cmd.op)
        OP_HALT_SET: endpoint_halted[ep_idx] <= 1'b1;
        OP_HALT_CLR: endpoint_halted[ep_idx] <= 1'b0;
        OP_SET_ADDR: device_address <= cmd.value_word[6:0];
        OP_SET_CONFIG: begin
          active_configuration <= (cfg_sel == 7'd0) ? 8'd0 : {1'b0, cfg_sel - 7'd1};
          active_alternate     <= '0;
        end
        OP_SET_IFACE: active_alternate <= cmd.value_word[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
